### rtl/assert_macros.svh
// Assertion macros shared by the block-average RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is high
`define BAVG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define BAVG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BAVG_ASSERT(label, clk, rst, prop, msg)
`define BAVG_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### rtl/bavg_pkg.sv
// Types and constants shared by the block-average design
package bavg_pkg;

  localparam int SAMPLE_W = 32;
  localparam int LEN_W    = 13;
  localparam int THR_W    = 7;
  localparam int CFG_W    = 13;

  // Sample value that marks missing data
  localparam logic signed [SAMPLE_W-1:0] MISSING_CODE = -32'sd32767;
  localparam logic [THR_W-1:0]           PCT_SCALE    = 7'd100;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd1;
  localparam logic [THR_W-1:0] THR_RESET = 7'd50;

  // Configuration register indexes
  typedef enum logic {
    REG_BLOCK_LENGTH = 1'b0,
    REG_THRESHOLD    = 1'b1
  } reg_index_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DIV   = 3'b100
  } state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/bavg_div.sv
// Restoring divider, one quotient bit per cycle
`include "assert_macros.svh"

module bavg_div import bavg_pkg::*; #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output div_stat_t        stat
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  dvs;

  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    diff;
  logic              fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    fits    = (shifted >= {1'b0, dvs});
    diff    = shifted - {1'b0, dvs};
  end

  // Count the steps and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift dividend bits in, quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign quot      = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  `BAVG_ASSERT(a_start_idle, clk, rst, start |-> !busy, "divider started while busy")
  `BAVG_ASSERT(a_done_pulse, clk, rst, done |=> !done, "divider done held over two cycles")
  `BAVG_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy), "divider done without a run")
  `BAVG_ASSERT(a_rem_below_dvs, clk, rst, busy |-> (rem < dvs), "remainder not below divisor")

endmodule

### rtl/block_average_with_missing_unit.sv
// Block averaging decimator with missing-value threshold, top level
//
//  channel | signals                                   | beat taken when
//  --------+-------------------------------------------+-----------------------
//  input   | in_valid, in_ready, sample                | in_valid && in_ready
//  output  | out_valid, out_ready, average, is_missing | out_valid && out_ready
//  config  | cfg_write, cfg_index, cfg_data            | cfg_write
//
// A mid-block sample is accumulated without leaving the idle state. The last
// sample of a block is accumulated, then passes the threshold check state and,
// when the block is not missing, the divide state of the bit-serial divider.
// No new sample is taken until the block's result is written.
// Reset clears the accumulators and loads length 1 and threshold 50.
// While the result register is full the block still takes mid-block samples
// but holds off a block-ending one until the result is taken.

`include "assert_macros.svh"

module block_average_with_missing_unit import bavg_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] average,
  output logic                       is_missing,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int PRD_W = CNT_W + THR_W;

  state_t                    state;
  logic [LEN_W-1:0]          block_length;
  logic [THR_W-1:0]          threshold;
  logic signed [SUM_W-1:0]   running_sum;
  logic [CNT_W-1:0]          samples_seen;
  logic [CNT_W-1:0]          missing_seen;
  logic                      neg;

  logic [CMP_W-1:0]          eff_len;
  logic [CNT_W-1:0]          seen_inc;
  logic                      block_end;
  logic                      sample_missing;
  logic                      in_beat;
  logic [CNT_W-1:0]          valid_count;
  logic [PRD_W-1:0]          miss_scaled;
  logic [PRD_W-1:0]          thr_scaled;
  logic                      declare_missing;
  logic [SUM_W-1:0]          sum_mag;
  logic                      div_start;
  logic [SUM_W-1:0]          div_quot;
  div_stat_t                 div_stat;
  logic [SAMPLE_W-1:0]       quot_low;

  // Effective length: zero counts as one, saturate at the block maximum
  always_comb begin
    if (block_length == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(block_length) > CMP_W'(MAX_BLOCK)) begin
      eff_len = CMP_W'(MAX_BLOCK);
    end else begin
      eff_len = CMP_W'(block_length);
    end
  end

  always_comb begin
    seen_inc       = samples_seen + 1'b1;
    block_end      = (CMP_W'(seen_inc) >= eff_len);
    sample_missing = (sample == MISSING_CODE);
    in_ready       = (state == ST_IDLE) && !(out_valid && block_end);
    in_beat        = in_valid && in_ready;
  end

  // Threshold check on the finished block
  always_comb begin
    valid_count     = samples_seen - missing_seen;
    miss_scaled     = PRD_W'(missing_seen) * PRD_W'(PCT_SCALE);
    thr_scaled      = PRD_W'(threshold) * PRD_W'(samples_seen);
    declare_missing = !(miss_scaled < thr_scaled) || (valid_count == '0);
    sum_mag         = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
    div_start       = (state == ST_CHECK) && !declare_missing;
    quot_low        = div_quot[SAMPLE_W-1:0];
  end

  bavg_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum_mag),
    .den   (valid_count),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= LEN_RESET;
      threshold    <= THR_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_BLOCK_LENGTH: block_length <= cfg_data[LEN_W-1:0];
        REG_THRESHOLD:    threshold    <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  // Sequencer, accumulators and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_sum  <= '0;
      samples_seen <= '0;
      missing_seen <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            samples_seen <= seen_inc;
            if (sample_missing) begin
              missing_seen <= missing_seen + 1'b1;
            end else begin
              running_sum <= running_sum + SUM_W'(sample);
            end
            if (block_end) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (declare_missing) begin
            out_valid    <= 1'b1;
            running_sum  <= '0;
            samples_seen <= '0;
            missing_seen <= '0;
            state        <= ST_IDLE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            out_valid    <= 1'b1;
            running_sum  <= '0;
            samples_seen <= '0;
            missing_seen <= '0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload and dividend sign
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      neg <= running_sum[SUM_W-1];
      if (declare_missing) begin
        average    <= MISSING_CODE;
        is_missing <= 1'b1;
      end
    end else if ((state == ST_DIV) && div_stat.done) begin
      average    <= neg ? $signed(-quot_low) : $signed(quot_low);
      is_missing <= 1'b0;
    end
  end

  `BAVG_ASSERT(a_check_slot_free, clk, rst, (state == ST_CHECK) |-> !out_valid, "result register full at block end")
  `BAVG_ASSERT(a_end_to_check, clk, rst, (in_beat && block_end) |=> (state == ST_CHECK), "block end not checked")
  `BAVG_ASSERT(a_done_in_div, clk, rst, div_stat.done |-> (state == ST_DIV), "divider finished outside divide state")
  `BAVG_ASSERT(a_miss_le_seen, clk, rst, missing_seen <= samples_seen, "more missing than seen samples")
  `BAVG_ASSERT(a_seen_bound, clk, rst, (state == ST_IDLE) |-> (CMP_W'(samples_seen) < CMP_W'(MAX_BLOCK)), "block count past maximum")

endmodule
